// File: sv/ecn_marking_policy_defines.svh
// ---------------------------------------------------------------------------
// ECN marking policy - assertion macros
// Concurrent assertion wrappers, empty when synthesising.
// ---------------------------------------------------------------------------
`ifndef ECN_MARKING_POLICY_DEFINES_SVH
`define ECN_MARKING_POLICY_DEFINES_SVH

`ifndef SYNTHESIS
`define ECN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ECN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ECN_ASSERT_SAME(label, ante, cons, msg)
`define ECN_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: sv/ecn_pkg.sv
// ---------------------------------------------------------------------------
// ECN marking policy - package
// Event codes, register indexes, widths and register reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecn_pkg;

    localparam int CMD_W = 2;
    localparam int IDX_W = 3;
    localparam int CFG_W = 32;

    localparam logic [CMD_W-1:0] CMD_ROUTE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FEEDBACK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SENT     = 2'd2;

    localparam logic [IDX_W-1:0] REG_FB_ECN       = 3'd0;
    localparam logic [IDX_W-1:0] REG_CTRL_ECN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_TMO_BEFORE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_TMO_AFTER    = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_GAP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_RETRY_DELAY  = 3'd5;

    localparam logic [CFG_W-1:0] RST_TMO_BEFORE  = 32'd500000;
    localparam logic [CFG_W-1:0] RST_TMO_AFTER   = 32'd5000000;
    localparam logic [CFG_W-1:0] RST_MAX_GAP     = 32'd200000;
    localparam logic [CFG_W-1:0] RST_RETRY_DELAY = 32'd10000000;

endpackage

// File: sv/ecn_in_if.sv
// ---------------------------------------------------------------------------
// ECN marking policy - event channel
// Valid/ready channel carrying one event word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ecn_in_if #(
    parameter int TIME_BITS = 48
);
    logic                        valid;
    logic                        ready;
    logic [ecn_pkg::CMD_W-1:0]   cmd;
    logic [TIME_BITS-1:0]        send_time_us;
    logic                        sent_marked;
    logic                        saw_bleached;
    logic                        saw_preserved;

    modport source (
        output valid, cmd, send_time_us, sent_marked, saw_bleached, saw_preserved,
        input  ready
    );
    modport sink (
        input  valid, cmd, send_time_us, sent_marked, saw_bleached, saw_preserved,
        output ready
    );
endinterface

// File: sv/ecn_out_if.sv
// ---------------------------------------------------------------------------
// ECN marking policy - result channel
// Valid/ready channel carrying one decision word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ecn_out_if;
    logic valid;
    logic ready;
    logic send_marked;
    logic decision_changed;
    logic drop_detected;
    logic retry_started;

    modport source (
        output valid, send_marked, decision_changed, drop_detected, retry_started,
        input  ready
    );
    modport sink (
        input  valid, send_marked, decision_changed, drop_detected, retry_started,
        output ready
    );
endinterface

// File: sv/ecn_marking_policy.sv
// Path: accept loads the input reg; the result reg loads once it can advance.
// One event per cycle if o_out.ready allows; route state updates in the same
// cycle as the result register loads, so the next event sees it at once.
// Reset (i_rst_n low, synchronous): empties both stages, clears route state,
// last send time and reported decision, and loads register defaults.
// ---------------------------------------------------------------------------
// ECN marking policy
// Per-event ECT(1) marking decision with drop detection and single retry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ecn_marking_policy_defines.svh"

module ecn_marking_policy #(
    parameter int TIME_BITS = 48,
    parameter int SUM_BITS  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ecn_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [ecn_pkg::CFG_W-1:0]  i_cfg_data,
    ecn_in_if.sink                     i_in,
    ecn_out_if.source                  o_out
);

    localparam int CW   = ecn_pkg::CFG_W;
    localparam int WIDE = (SUM_BITS > CW) ? SUM_BITS : CW;
    localparam logic [SUM_BITS-1:0] SUM_ALL = '1;

    // configuration
    logic          r_fb_ecn;
    logic          r_ctrl_ecn;
    logic [CW-1:0] r_tmo_before;
    logic [CW-1:0] r_tmo_after;
    logic [CW-1:0] r_max_gap;
    logic [CW-1:0] r_retry_delay;

    // route state
    logic                 r_bleach;
    logic                 r_drop_vld;
    logic [TIME_BITS-1:0] r_drop_time;
    logic                 r_retried;
    logic                 r_pres_seen;
    logic [SUM_BITS-1:0]  r_unans;
    logic                 r_last_vld;
    logic [TIME_BITS-1:0] r_last_time;
    logic                 r_reported;

    // input stage
    logic                      r_in_vld;
    logic [ecn_pkg::CMD_W-1:0] r_in_cmd;
    logic [TIME_BITS-1:0]      r_in_time;
    logic                      r_in_marked;
    logic                      r_in_bleached;
    logic                      r_in_preserved;

    // result stage
    logic r_out_vld;
    logic r_out_marked;
    logic r_out_changed;
    logic r_out_drop;
    logic r_out_retry;

    logic adv;
    logic fire;

    logic                 n_bleach;
    logic                 n_drop_vld;
    logic [TIME_BITS-1:0] n_drop_time;
    logic                 n_retried;
    logic                 n_pres_seen;
    logic [SUM_BITS-1:0]  n_unans;
    logic                 n_last_vld;
    logic [TIME_BITS-1:0] n_last_time;
    logic                 n_detected;
    logic                 n_retry;
    logic                 n_now;

    logic [TIME_BITS-1:0] drop_diff;
    logic [TIME_BITS-1:0] gap_raw;
    logic [CW-1:0]        gap;
    logic [WIDE:0]        sum_w;
    logic [CW-1:0]        limit;

    logic n_cfg_fb;
    logic n_cfg_ctrl;
    logic cfg_hit;

    assign adv        = !r_out_vld || o_out.ready;
    assign fire       = r_in_vld && adv;
    assign i_in.ready = !r_in_vld || adv;

    assign drop_diff = r_in_time - r_drop_time;
    assign gap_raw   = r_in_time - r_last_time;

    always_comb begin
        n_bleach    = r_bleach;
        n_drop_vld  = r_drop_vld;
        n_drop_time = r_drop_time;
        n_retried   = r_retried;
        n_pres_seen = r_pres_seen;
        n_unans     = r_unans;
        n_last_vld  = r_last_vld;
        n_last_time = r_last_time;
        n_detected  = 1'b0;
        n_retry     = 1'b0;
        gap         = '0;
        sum_w       = '0;
        limit       = r_pres_seen ? r_tmo_after : r_tmo_before;
        case (r_in_cmd)
            ecn_pkg::CMD_ROUTE: begin
                n_bleach    = 1'b0;
                n_drop_vld  = 1'b0;
                n_drop_time = '0;
                n_retried   = 1'b0;
                n_pres_seen = 1'b0;
                n_unans     = '0;
            end
            ecn_pkg::CMD_FEEDBACK: begin
                n_unans = '0;
                if (r_in_preserved) begin
                    n_pres_seen = 1'b1;
                end
                if (r_in_bleached) begin
                    n_bleach = 1'b1;
                end
            end
            ecn_pkg::CMD_SENT: begin
                if (r_drop_vld && !r_retried && (r_in_time > r_drop_time) &&
                    (drop_diff > TIME_BITS'(r_retry_delay))) begin
                    n_retried   = 1'b1;
                    n_drop_vld  = 1'b0;
                    n_drop_time = '0;
                    n_unans     = '0;
                    n_retry     = 1'b1;
                end
                if (r_in_marked) begin
                    if (r_last_vld && (r_in_time > r_last_time)) begin
                        if (gap_raw > TIME_BITS'(r_max_gap)) begin
                            gap = r_max_gap;
                        end else begin
                            gap = gap_raw[CW-1:0];
                        end
                        sum_w = (WIDE+1)'(n_unans) + (WIDE+1)'(gap);
                        if (sum_w > (WIDE+1)'(SUM_ALL)) begin
                            n_unans = SUM_ALL;
                        end else begin
                            n_unans = sum_w[SUM_BITS-1:0];
                        end
                    end
                    if (!n_drop_vld && (WIDE'(n_unans) > WIDE'(limit))) begin
                        n_drop_vld  = 1'b1;
                        n_drop_time = r_in_time;
                        n_detected  = 1'b1;
                    end
                end
                n_last_vld  = 1'b1;
                n_last_time = r_in_time;
            end
            default: begin
            end
        endcase
        n_now = r_fb_ecn && r_ctrl_ecn && !n_bleach && !n_drop_vld;
    end

    // decision as it stands after a register write
    assign n_cfg_fb   = (i_cfg_idx == ecn_pkg::REG_FB_ECN)   ? i_cfg_data[0] : r_fb_ecn;
    assign n_cfg_ctrl = (i_cfg_idx == ecn_pkg::REG_CTRL_ECN) ? i_cfg_data[0] : r_ctrl_ecn;
    assign cfg_hit    = (i_cfg_idx <= ecn_pkg::REG_RETRY_DELAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_ecn      <= 1'b0;
            r_ctrl_ecn    <= 1'b0;
            r_tmo_before  <= ecn_pkg::RST_TMO_BEFORE;
            r_tmo_after   <= ecn_pkg::RST_TMO_AFTER;
            r_max_gap     <= ecn_pkg::RST_MAX_GAP;
            r_retry_delay <= ecn_pkg::RST_RETRY_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ecn_pkg::REG_FB_ECN:      r_fb_ecn      <= i_cfg_data[0];
                ecn_pkg::REG_CTRL_ECN:    r_ctrl_ecn    <= i_cfg_data[0];
                ecn_pkg::REG_TMO_BEFORE:  r_tmo_before  <= i_cfg_data;
                ecn_pkg::REG_TMO_AFTER:   r_tmo_after   <= i_cfg_data;
                ecn_pkg::REG_MAX_GAP:     r_max_gap     <= i_cfg_data;
                ecn_pkg::REG_RETRY_DELAY: r_retry_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bleach    <= 1'b0;
            r_drop_vld  <= 1'b0;
            r_drop_time <= '0;
            r_retried   <= 1'b0;
            r_pres_seen <= 1'b0;
            r_unans     <= '0;
            r_last_vld  <= 1'b0;
            r_last_time <= '0;
            r_reported  <= 1'b0;
        end else if (fire) begin
            r_bleach    <= n_bleach;
            r_drop_vld  <= n_drop_vld;
            r_drop_time <= n_drop_time;
            r_retried   <= n_retried;
            r_pres_seen <= n_pres_seen;
            r_unans     <= n_unans;
            r_last_vld  <= n_last_vld;
            r_last_time <= n_last_time;
            r_reported  <= n_now;
        end else if (i_cfg_we && cfg_hit) begin
            r_reported <= n_cfg_fb && n_cfg_ctrl && !r_bleach && !r_drop_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_cmd       <= i_in.cmd;
            r_in_time      <= i_in.send_time_us;
            r_in_marked    <= i_in.sent_marked;
            r_in_bleached  <= i_in.saw_bleached;
            r_in_preserved <= i_in.saw_preserved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_marked  <= n_now;
            r_out_changed <= (n_now != r_reported);
            r_out_drop    <= n_detected;
            r_out_retry   <= n_retry;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.send_marked      = r_out_marked;
    assign o_out.decision_changed = r_out_changed;
    assign o_out.drop_detected    = r_out_drop;
    assign o_out.retry_started    = r_out_retry;

    // a fresh drop always withdraws marking
    `ECN_ASSERT_SAME(a_drop_unmarks, o_out.valid && o_out.drop_detected, !o_out.send_marked, "drop reported while still marking")
    // a reported drop or retry must be reflected in the route state
    `ECN_ASSERT_SAME(a_drop_state, o_out.valid && o_out.drop_detected, r_drop_vld, "drop reported but not held")
    `ECN_ASSERT_SAME(a_retry_state, o_out.valid && o_out.retry_started, r_retried, "retry reported but not recorded")
    // a word leaving the input stage reaches the result stage next
    `ECN_ASSERT_NEXT(a_stage_move, fire, r_out_vld, "result word lost")

endmodule
